// ----- hdl/hfmf_pkg.sv -----
// shared constants and types for the hole fill mode filter
`timescale 1ns / 1ps

package hfmf_pkg;

    localparam int DEFAULT_MAX_WIDTH  = 512;
    localparam int DEFAULT_COLOR_BITS = 4;
    localparam int MAX_HEIGHT         = 512;
    localparam int COORD_BITS         = 9;

    // configuration port
    localparam int CFG_DATA_BITS  = 10;
    localparam int CFG_INDEX_BITS = 2;
    localparam int MIN_VOTES_BITS = 4;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_VOTES    = 2'd2;

    localparam logic [CFG_DATA_BITS-1:0]  RESET_FRAME_WIDTH  = 10'd320;
    localparam logic [CFG_DATA_BITS-1:0]  RESET_FRAME_HEIGHT = 10'd224;
    localparam logic [MIN_VOTES_BITS-1:0] RESET_MIN_VOTES    = 4'd5;

    // 3x3 window, row-major, top-left first
    localparam int WIN_SIZE   = 9;
    localparam int NBR_COUNT  = 8;
    localparam int CENTER_POS = 4;
    localparam int SIDE_POS   = 5;
    localparam int NEW_POS    = 8;
    localparam int VOTE_BITS  = 4;

    localparam int MAX_RESULTS = 3;
    localparam int SLOT_BITS   = 2;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  lag;
        logic                  row_gt0;
        logic                  border;
        logic                  row_end;
        logic                  last_row;
    } item_info_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  done;
    } out_pos_t;

endpackage

// ----- hdl/hfmf_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps

module hfmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/hfmf_vote.sv -----
// two step neighbor vote: per-color running counts, then winner select
`timescale 1ns / 1ps

module hfmf_vote #(
    parameter int COLOR_BITS = hfmf_pkg::DEFAULT_COLOR_BITS
) (
    input  logic                                   clk,
    input  logic                                   en,
    input  logic [hfmf_pkg::WIN_SIZE-1:0][COLOR_BITS-1:0] window,
    input  logic                                   border,
    input  logic [hfmf_pkg::MIN_VOTES_BITS-1:0]    min_votes,
    output logic [COLOR_BITS-1:0]                  fill_color
);

    import hfmf_pkg::*;

    logic [NBR_COUNT-1:0][COLOR_BITS-1:0] nb;
    logic [NBR_COUNT-1:0][VOTE_BITS-1:0]  cnt_next;
    logic [VOTE_BITS-1:0]                 total_next;

    logic [NBR_COUNT-1:0][COLOR_BITS-1:0] nb_reg;
    logic [NBR_COUNT-1:0][VOTE_BITS-1:0]  cnt_reg;
    logic [VOTE_BITS-1:0]                 total_reg;
    logic [COLOR_BITS-1:0]                center_reg;
    logic                                 border_reg;

    logic [VOTE_BITS-1:0]  best_cnt;
    logic [COLOR_BITS-1:0] winner;
    logic                  fill;

    // count of each neighbor's color up to and including its own scan position
    always_comb
    begin
        for (int k = 0; k < NBR_COUNT; k++)
        begin
            nb[k] = window[(k < CENTER_POS) ? k : k + 1];
        end
        total_next = '0;
        for (int k = 0; k < NBR_COUNT; k++)
        begin
            cnt_next[k] = '0;
            if (nb[k] != '0)
            begin
                cnt_next[k] = VOTE_BITS'(1);
                for (int i = 0; i < k; i++)
                begin
                    if (nb[i] == nb[k])
                    begin
                        cnt_next[k] = cnt_next[k] + VOTE_BITS'(1);
                    end
                end
                total_next = total_next + VOTE_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nb_reg     <= nb;
            cnt_reg    <= cnt_next;
            total_reg  <= total_next;
            center_reg <= window[CENTER_POS];
            border_reg <= border;
        end
    end

    // the color first reaching the top count wins a tie
    always_comb
    begin
        best_cnt = '0;
        for (int k = 0; k < NBR_COUNT; k++)
        begin
            if (cnt_reg[k] > best_cnt)
            begin
                best_cnt = cnt_reg[k];
            end
        end
        winner = '0;
        for (int k = NBR_COUNT - 1; k >= 0; k--)
        begin
            if (best_cnt != '0 && cnt_reg[k] == best_cnt)
            begin
                winner = nb_reg[k];
            end
        end
        fill = (total_reg != '0) && (total_reg >= min_votes);
        if (border_reg || center_reg != '0)
        begin
            fill_color = center_reg;
        end
        else if (fill)
        begin
            fill_color = winner;
        end
        else
        begin
            fill_color = '0;
        end
    end

endmodule

// ----- hdl/hole_fill_mode_filter_top.sv -----
// top level of the 3x3 hole fill mode filter
`timescale 1ns / 1ps

// Usage
// in channel (in_valid/in_ready, pixel_color) takes palette pixels in raster
// order, one word per cycle. out channel (out_valid/out_ready) gives out_color
// with out_x, out_y and frame_done; rows come out one line behind the input.
// cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes frame_width,
// frame_height and min_votes; cfg_ready is always high; write only when idle.
// Each input word gives up to three output words (lagged pixel, row end pixel,
// last row pixel). The pipeline runs line store read, window shift, neighbor
// count and winner select, then loads a word's results into the output buffer.
// Throughput is one input word per cycle while each word gives at most one
// result and out_ready is high; a word that gives two or three results holds
// the input while the single output port drains the 3-slot buffer.
// The two line stores share one memory with one read and one write port; a
// read of the column just written is forwarded from the write data.
// Reset clears the counters, the window and the pipeline and restores the
// register defaults 320, 224 and 5; no clearing pass is needed.
// When out_ready is low the output buffer holds and the pipeline backs up
// into in_ready with no loss.

module hole_fill_mode_filter_top #(
    parameter int MAX_WIDTH  = hfmf_pkg::DEFAULT_MAX_WIDTH,
    parameter int COLOR_BITS = hfmf_pkg::DEFAULT_COLOR_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [COLOR_BITS-1:0]                pixel_color,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [COLOR_BITS-1:0]                out_color,
    output logic [hfmf_pkg::COORD_BITS-1:0]      out_x,
    output logic [hfmf_pkg::COORD_BITS-1:0]      out_y,
    output logic                                 frame_done,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [hfmf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [hfmf_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    import hfmf_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW + 1 > CFG_DATA_BITS) ? CW + 1 : CFG_DATA_BITS;
    localparam int MW = 2 * COLOR_BITS;

    // configuration
    logic [CFG_DATA_BITS-1:0]  cfg_width_reg;
    logic [CFG_DATA_BITS-1:0]  cfg_height_reg;
    logic [MIN_VOTES_BITS-1:0] cfg_votes_reg;
    logic [WW-1:0]             width_ext;
    logic [WW-1:0]             w_last;
    logic [COORD_BITS-1:0]     h_last;

    // input position
    logic [CW-1:0]         col_count_reg;
    logic [COORD_BITS-1:0] row_count_reg;
    logic [CW-1:0]         col_count_next;
    logic [COORD_BITS-1:0] row_count_next;
    logic [WW-1:0]         col_ext;
    logic [CW+COORD_BITS-1:0] col_wide;
    item_info_t            acc_info;
    logic                  in_accept;

    // pipeline stages
    logic                  s1_valid_reg;
    item_info_t            s1_info_reg;
    logic [CW-1:0]         s1_addr_reg;
    logic [COLOR_BITS-1:0] s1_pix_reg;
    logic                  s2_valid_reg;
    item_info_t            s2_info_reg;
    logic                  s3_valid_reg;
    item_info_t            s3_info_reg;
    logic [COLOR_BITS-1:0] s3_side_reg;
    logic [COLOR_BITS-1:0] s3_pix_reg;
    logic                  s1_go;
    logic                  s2_go;
    logic                  s3_go;
    logic                  s2_ready;
    logic                  s3_ready;

    // line store memory, upper row in the high half
    logic [MW-1:0]         ram_rdata;
    logic [MW-1:0]         ram_wdata;
    logic [MW-1:0]         rd_word;
    logic                  fwd_valid_reg;
    logic [MW-1:0]         fwd_data_reg;
    logic [COLOR_BITS-1:0] rd_upper;
    logic [COLOR_BITS-1:0] rd_lower;

    logic [WIN_SIZE-1:0][COLOR_BITS-1:0] win_reg;
    logic [WIN_SIZE-1:0][COLOR_BITS-1:0] win_next;

    logic [COLOR_BITS-1:0] vote_color;

    // output buffer
    logic [MAX_RESULTS-1:0][COLOR_BITS-1:0] slot_col_reg;
    out_pos_t [MAX_RESULTS-1:0]             slot_pos_reg;
    logic [SLOT_BITS-1:0]                   emit_cnt_reg;
    logic [MAX_RESULTS-1:0][COLOR_BITS-1:0] load_col;
    out_pos_t [MAX_RESULTS-1:0]             load_pos;
    logic [MAX_RESULTS-1:0][COLOR_BITS-1:0] res_col;
    out_pos_t [MAX_RESULTS-1:0]             res_pos;
    logic [MAX_RESULTS-1:0]                 res_en;
    logic [SLOT_BITS-1:0]                   load_cnt;
    logic                                   emit_free;
    logic                                   out_accept;

    assign cfg_ready = 1'b1;

    // effective sizes, as last index
    always_comb
    begin
        width_ext = WW'(cfg_width_reg);
        if (width_ext == '0)
        begin
            w_last = '0;
        end
        else if (width_ext > WW'(MAX_WIDTH))
        begin
            w_last = WW'(MAX_WIDTH - 1);
        end
        else
        begin
            w_last = width_ext - WW'(1);
        end
        if (cfg_height_reg == '0)
        begin
            h_last = '0;
        end
        else if (cfg_height_reg > CFG_DATA_BITS'(MAX_HEIGHT))
        begin
            h_last = COORD_BITS'(MAX_HEIGHT - 1);
        end
        else
        begin
            h_last = COORD_BITS'(cfg_height_reg - CFG_DATA_BITS'(1));
        end
    end

    // position flags of the word being taken
    always_comb
    begin
        col_ext           = WW'(col_count_reg);
        col_wide          = {{COORD_BITS{1'b0}}, col_count_reg};
        acc_info.x        = col_wide[COORD_BITS-1:0];
        acc_info.y        = row_count_reg;
        acc_info.row_gt0  = row_count_reg != '0;
        acc_info.lag      = (row_count_reg != '0) && (col_count_reg != '0);
        acc_info.border   = (col_ext == WW'(1)) || (col_ext > w_last)
                            || (row_count_reg == COORD_BITS'(1));
        acc_info.row_end  = col_ext >= w_last;
        acc_info.last_row = row_count_reg >= h_last;
        if (acc_info.row_end)
        begin
            col_count_next = '0;
            row_count_next = acc_info.last_row ? '0 : row_count_reg + COORD_BITS'(1);
        end
        else
        begin
            col_count_next = col_count_reg + CW'(1);
            row_count_next = row_count_reg;
        end
    end

    assign s3_ready   = !s3_valid_reg || emit_free;
    assign s2_ready   = !s2_valid_reg || s3_ready;
    assign in_ready   = !s1_valid_reg || s2_ready;
    assign in_accept  = in_valid && in_ready;
    assign s1_go      = s1_valid_reg && s2_ready;
    assign s2_go      = s2_valid_reg && s3_ready;
    assign emit_free  = (emit_cnt_reg == '0) || (emit_cnt_reg == SLOT_BITS'(1) && out_ready);
    assign s3_go      = s3_valid_reg && emit_free;
    assign out_valid  = emit_cnt_reg != '0;
    assign out_accept = out_valid && out_ready;

    assign rd_word   = fwd_valid_reg ? fwd_data_reg : ram_rdata;
    assign rd_upper  = rd_word[MW-1:COLOR_BITS];
    assign rd_lower  = rd_word[COLOR_BITS-1:0];
    assign ram_wdata = {rd_lower, s1_pix_reg};

    hfmf_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_go),
        .waddr (s1_addr_reg),
        .wdata (ram_wdata),
        .re    (in_accept),
        .raddr (col_count_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            win_next[i*3]     = win_reg[i*3+1];
            win_next[i*3 + 1] = win_reg[i*3+2];
        end
        win_next[2]       = rd_upper;
        win_next[SIDE_POS] = rd_lower;
        win_next[NEW_POS]  = s1_pix_reg;
    end

    // win_reg holds the stage 2 word's window until that word moves on
    hfmf_vote #(
        .COLOR_BITS (COLOR_BITS)
    ) u_vote (
        .clk        (clk),
        .en         (s2_go),
        .window     (win_reg),
        .border     (s2_info_reg.border),
        .min_votes  (cfg_votes_reg),
        .fill_color (vote_color)
    );

    // results of the stage 3 word, packed to the front
    always_comb
    begin
        res_en[0]       = s3_info_reg.lag;
        res_en[1]       = s3_info_reg.row_gt0 && s3_info_reg.row_end;
        res_en[2]       = s3_info_reg.last_row;
        res_col[0]      = vote_color;
        res_col[1]      = s3_side_reg;
        res_col[2]      = s3_pix_reg;
        res_pos[0].x    = s3_info_reg.x - COORD_BITS'(1);
        res_pos[0].y    = s3_info_reg.y - COORD_BITS'(1);
        res_pos[0].done = 1'b0;
        res_pos[1].x    = s3_info_reg.x;
        res_pos[1].y    = s3_info_reg.y - COORD_BITS'(1);
        res_pos[1].done = 1'b0;
        res_pos[2].x    = s3_info_reg.x;
        res_pos[2].y    = s3_info_reg.y;
        res_pos[2].done = s3_info_reg.row_end && s3_info_reg.last_row;

        load_col[2] = res_col[2];
        load_pos[2] = res_pos[2];
        if (res_en[0] && res_en[1])
        begin
            load_col[1] = res_col[1];
            load_pos[1] = res_pos[1];
        end
        else
        begin
            load_col[1] = res_col[2];
            load_pos[1] = res_pos[2];
        end
        if (res_en[0])
        begin
            load_col[0] = res_col[0];
            load_pos[0] = res_pos[0];
        end
        else if (res_en[1])
        begin
            load_col[0] = res_col[1];
            load_pos[0] = res_pos[1];
        end
        else
        begin
            load_col[0] = res_col[2];
            load_pos[0] = res_pos[2];
        end
        load_cnt = SLOT_BITS'(res_en[0]) + SLOT_BITS'(res_en[1]) + SLOT_BITS'(res_en[2]);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_width_reg  <= RESET_FRAME_WIDTH;
            cfg_height_reg <= RESET_FRAME_HEIGHT;
            cfg_votes_reg  <= RESET_MIN_VOTES;
            col_count_reg  <= '0;
            row_count_reg  <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            win_reg        <= '0;
            emit_cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FRAME_WIDTH:  cfg_width_reg  <= cfg_data;
                    CFG_FRAME_HEIGHT: cfg_height_reg <= cfg_data;
                    CFG_MIN_VOTES:    cfg_votes_reg  <= cfg_data[MIN_VOTES_BITS-1:0];
                    default:          ;
                endcase
            end
            if (in_accept)
            begin
                col_count_reg <= col_count_next;
                row_count_reg <= row_count_next;
                // same column written back at this edge: ram returns the old word
                fwd_valid_reg <= s1_go && (s1_addr_reg == col_count_reg);
            end
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_go)
            begin
                win_reg      <= win_next;
                s2_valid_reg <= 1'b1;
            end
            else if (s2_go)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_go)
            begin
                s3_valid_reg <= 1'b1;
            end
            else if (s3_go)
            begin
                s3_valid_reg <= 1'b0;
            end
            if (s3_go)
            begin
                emit_cnt_reg <= load_cnt;
            end
            else if (out_accept)
            begin
                emit_cnt_reg <= emit_cnt_reg - SLOT_BITS'(1);
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_info_reg  <= acc_info;
            s1_addr_reg  <= col_count_reg;
            s1_pix_reg   <= pixel_color;
            fwd_data_reg <= ram_wdata;
        end
        if (s1_go)
        begin
            s2_info_reg <= s1_info_reg;
        end
        if (s2_go)
        begin
            s3_info_reg <= s2_info_reg;
            s3_side_reg <= win_reg[SIDE_POS];
            s3_pix_reg  <= win_reg[NEW_POS];
        end
        if (s3_go)
        begin
            slot_col_reg <= load_col;
            slot_pos_reg <= load_pos;
        end
        else if (out_accept)
        begin
            for (int k = 0; k < MAX_RESULTS - 1; k++)
            begin
                slot_col_reg[k] <= slot_col_reg[k+1];
                slot_pos_reg[k] <= slot_pos_reg[k+1];
            end
        end
    end

    assign out_color  = slot_col_reg[0];
    assign out_x      = slot_pos_reg[0].x;
    assign out_y      = slot_pos_reg[0].y;
    assign frame_done = slot_pos_reg[0].done;

    // a stalled stage 1 word keeps its line store read
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_ready |=> s1_valid_reg && $stable(ram_rdata))
        else $error("line store read data lost under stall");

    // the window belongs to the stage 2 word while it waits
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !s3_ready |=> s2_valid_reg && $stable(win_reg))
        else $error("window overwritten under stall");

    // the frame end word is always the last one of its group
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> emit_cnt_reg == SLOT_BITS'(1))
        else $error("frame end word not last in output buffer");

    // a taken word always lands in stage 1
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> s1_valid_reg)
        else $error("accepted word dropped");

    // output buffer is only reloaded once it drains
    assert property (@(posedge clk) disable iff (!rst_n)
        s3_go && emit_cnt_reg > SLOT_BITS'(1) |-> 1'b0)
        else $error("output buffer overrun");

endmodule

// ----- verif/hole_fill_mode_filter_top_tb.sv -----
// self-checking testbench for the hole fill mode filter top level
`timescale 1ns / 1ps

module hole_fill_mode_filter_top_tb;

    import hfmf_pkg::*;

    localparam int CBITS        = DEFAULT_COLOR_BITS;
    localparam int LINE_LEN     = DEFAULT_MAX_WIDTH;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_REPORTS  = 10;
    localparam int RANDOM_ITEMS = 100;

    typedef logic [CBITS-1:0]      color_t;
    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        color_t color;
        coord_t x;
        coord_t y;
        logic   done;
    } pixel_word_t;

    logic                      clk         = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      in_valid    = 1'b0;
    logic                      in_ready;
    color_t                    pixel_color = '0;
    logic                      out_valid;
    logic                      out_ready   = 1'b0;
    color_t                    out_color;
    coord_t                    out_x;
    coord_t                    out_y;
    logic                      frame_done;
    logic                      cfg_valid   = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index   = CFG_FRAME_WIDTH;
    logic [CFG_DATA_BITS-1:0]  cfg_data    = '0;

    // filter state as the block should hold it
    color_t                    row_above2 [LINE_LEN];
    color_t                    row_above1 [LINE_LEN];
    color_t                    win [3][3];
    int unsigned               scan_x;
    int unsigned               scan_y;
    logic [CFG_DATA_BITS-1:0]  width_reg  = RESET_FRAME_WIDTH;
    logic [CFG_DATA_BITS-1:0]  height_reg = RESET_FRAME_HEIGHT;
    logic [MIN_VOTES_BITS-1:0] votes_reg  = RESET_MIN_VOTES;

    pixel_word_t expected_pixels [$];
    int          fail_count  = 0;
    int unsigned pixels_sent = 0;
    bit          calm        = 1'b0;
    int          rx_hold     = 0;

    hole_fill_mode_filter_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel_color (pixel_color),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_color   (out_color),
        .out_x       (out_x),
        .out_y       (out_y),
        .frame_done  (frame_done),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic int unsigned eff_size(input logic [CFG_DATA_BITS-1:0] v,
                                             input int unsigned lim);
        if (v == 0)
            return 1;
        return (v > lim) ? lim : v;
    endfunction

    // most frequent nonzero neighbor, earliest to reach the top count wins
    function automatic color_t mode_of_neighbors();
        int unsigned tally [1 << CBITS];
        int unsigned seen;
        color_t      best;
        color_t      c;
        if (win[1][1] != 0)
            return win[1][1];
        seen = 0;
        best = '0;
        foreach (tally[k])
            tally[k] = 0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                c = win[i][j];
                if (c != 0)
                begin
                    tally[c]++;
                    seen++;
                    if (tally[c] > tally[best])
                        best = c;
                end
            end
        end
        return (seen >= votes_reg && best != 0) ? best : color_t'(0);
    endfunction

    function automatic void queue_word(input color_t color, input int unsigned x,
                                       input int unsigned y, input logic done);
        pixel_word_t w;
        w.color = color;
        w.x     = coord_t'(x);
        w.y     = coord_t'(y);
        w.done  = done;
        expected_pixels.push_back(w);
    endfunction

    task automatic filter_pixel(input color_t pix);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int unsigned idx;
        bit          row_end;
        bit          last_row;
        bit          border;
        w        = eff_size(width_reg, LINE_LEN);
        h        = eff_size(height_reg, MAX_HEIGHT);
        c        = scan_x;
        r        = scan_y;
        idx      = (c < LINE_LEN) ? c : LINE_LEN - 1;
        row_end  = (c >= w - 1);
        last_row = (r >= h - 1);
        for (int i = 0; i < 3; i++)
        begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2]       = row_above2[idx];
        win[1][2]       = row_above1[idx];
        win[2][2]       = pix;
        row_above2[idx] = row_above1[idx];
        row_above1[idx] = pix;
        if (r >= 1 && c >= 1)
        begin
            border = (c - 1 == 0) || (c - 1 >= w - 1) || (r - 1 == 0);
            queue_word(border ? win[1][1] : mode_of_neighbors(), c - 1, r - 1, 1'b0);
        end
        if (r >= 1 && row_end)
            queue_word(win[1][2], c, r - 1, 1'b0);
        if (last_row)
            queue_word(pix, c, r, row_end);
        if (row_end)
        begin
            scan_x = 0;
            scan_y = last_row ? 0 : r + 1;
        end
        else
            scan_x = c + 1;
    endtask

    task automatic send_pixel(input color_t pix);
        while (!calm && $urandom_range(0, 99) < 22)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        pixel_color <= pix;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        filter_pixel(pix);
        pixels_sent++;
    endtask

    // wait for every expected word, then for words that cause none
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input int unsigned w, input int unsigned h,
                             input int unsigned mv);
        logic [CFG_INDEX_BITS-1:0] idx [3];
        int unsigned               val [3];
        idx = '{CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT, CFG_MIN_VOTES};
        val = '{w, h, mv};
        for (int k = 0; k < 3; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k][CFG_DATA_BITS-1:0];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (idx[k])
                CFG_FRAME_WIDTH:  width_reg  = val[k][CFG_DATA_BITS-1:0];
                CFG_FRAME_HEIGHT: height_reg = val[k][CFG_DATA_BITS-1:0];
                CFG_MIN_VOTES:    votes_reg  = val[k][MIN_VOTES_BITS-1:0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic color_t random_pixel(input int unsigned hole_pct,
                                            input int unsigned top);
        if ($urandom_range(0, 99) < hole_pct)
            return '0;
        return color_t'($urandom_range(1, top));
    endfunction

    // sends until the frame wraps; may shrink the frame or retune votes midway
    task automatic send_frame(input int unsigned hole_pct, input int unsigned top,
                              input bit shrink);
        int unsigned cut;
        int unsigned sent;
        cut  = $urandom_range(2, 40);
        sent = 0;
        do
        begin
            send_pixel(random_pixel(hole_pct, top));
            sent++;
            if (shrink && sent == cut && (scan_x != 0 || scan_y != 0))
            begin
                settle();
                configure($urandom_range(1, eff_size(width_reg, LINE_LEN)),
                          $urandom_range(1, eff_size(height_reg, MAX_HEIGHT)),
                          $urandom_range(0, 9));
            end
        end
        while (scan_x != 0 || scan_y != 0);
    endtask

    task automatic test_directed_cases();
        color_t majority [9] = '{4'd1, 4'd2, 4'd1, 4'd2, 4'd0, 4'd2, 4'd15, 4'd2, 4'd3};
        color_t tie      [9] = '{4'd6, 4'd5, 4'd5, 4'd6, 4'd0, 4'd7, 4'd7, 4'd8, 4'd8};
        configure(3, 3, 5);
        foreach (majority[k])
            send_pixel(majority[k]);
        settle();
        // all eight neighbors set, color that first reached two wins
        configure(3, 3, 8);
        foreach (tie[k])
            send_pixel(tie[k]);
        settle();
        // zero sizes act as a single pixel frame
        configure(0, 0, 0);
        send_pixel(4'd0);
        send_pixel(4'd15);
        settle();
    endtask

    task automatic test_random_frames();
        int unsigned start;
        int unsigned w;
        int unsigned mv;
        start = pixels_sent;
        while (pixels_sent - start < RANDOM_ITEMS)
        begin
            settle();
            w  = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 8) : $urandom_range(9, 24);
            mv = ($urandom_range(0, 99) < 25) ? $urandom_range(0, 15) : $urandom_range(1, 8);
            configure(w, $urandom_range(1, 6), mv);
            send_frame($urandom_range(20, 60), $urandom_range(0, 1) ? 15 : 3,
                       $urandom_range(0, 99) < 25);
        end
    endtask

    task automatic test_output_stall();
        settle();
        configure(8, 3, 3);
        // receiver holds off while the sender keeps offering words
        calm    = 1'b1;
        rx_hold = 120;
        send_frame(40, 15, 1'b0);
        calm = 1'b0;
        // sender pauses midway until everything is out
        for (int k = 0; k < 10; k++)
            send_pixel(random_pixel(40, 3));
        settle();
        send_frame(40, 3, 1'b0);
    endtask

    task automatic test_widest_and_tallest();
        settle();
        // sizes past the limit saturate; each frame is then cut short
        configure(1023, 2, 4);
        calm = 1'b1;
        for (int k = 0; k < 10; k++)
            send_pixel(random_pixel(30, 15));
        calm = 1'b0;
        settle();
        configure(10, 2, 4);
        send_frame(30, 15, 1'b0);
        settle();
        configure(3, 1023, 5);
        for (int k = 0; k < 9; k++)
            send_pixel(random_pixel(30, 15));
        settle();
        configure(3, 4, 5);
        send_frame(30, 15, 1'b0);
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rx_hold > 0)
            begin
                out_ready <= 1'b0;
                rx_hold--;
            end
            else
                out_ready <= calm || ($urandom_range(0, 99) >= 22);
        end
    end

    always @(posedge clk)
    begin
        pixel_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected word: color %0d x %0d y %0d done %0b",
                             out_color, out_x, out_y, frame_done);
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (want.color !== out_color || want.x !== out_x ||
                    want.y !== out_y || want.done !== frame_done)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("mismatch: expected color %0d x %0d y %0d done %0b, %s",
                                 want.color, want.x, want.y, want.done,
                                 $sformatf("got color %0d x %0d y %0d done %0b",
                                           out_color, out_x, out_y, frame_done));
                end
            end
        end
    end

    initial
    begin
        #(400000 * 8);
        $display("** hole_fill_mode_filter_top: FAILED **");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < LINE_LEN; i++)
        begin
            row_above2[i] = '0;
            row_above1[i] = '0;
        end
        foreach (win[i, j])
            win[i][j] = '0;
        scan_x = 0;
        scan_y = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_random_frames();
        test_output_stall();
        test_widest_and_tallest();
        in_valid <= 1'b0;
        for (int n = 0; n < 5000 && expected_pixels.size() != 0; n++)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        fail_count += expected_pixels.size();
        if (fail_count == 0)
            $display("** hole_fill_mode_filter_top: PASSED **");
        else
            $display("** hole_fill_mode_filter_top: FAILED **");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/hfmf_pkg.sv
hdl/hfmf_ram.sv
hdl/hfmf_vote.sv
hdl/hole_fill_mode_filter_top.sv
verif/hole_fill_mode_filter_top_tb.sv
